// ===== rtl/core/rcmap_pkg.sv =====
// rcmap_pkg: shared types, constants and codes of the refcount allocation map
// no dependencies; used by every file under rtl/core

package rcmap_pkg;

  // field widths
  localparam int IDX_W   = 12;
  localparam int POS_W   = 13;
  localparam int CNT_W   = 2;
  localparam int KIND_W  = 2;

  // saturation limit of the 13-bit counter and hint
  localparam logic [POS_W-1:0] POS_MAX = 13'h1fff;

  // default size and reset value of the entry count
  localparam int ENTRIES_DEFAULT = 4096;
  localparam int RESET_ENTRIES   = 4096;

  // one memory row holds this many 2-bit counts
  localparam int ROW_ENTRIES = 32;
  localparam int SLOT_W      = $clog2(ROW_ENTRIES);
  localparam int ROW_BITS    = ROW_ENTRIES * CNT_W;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'b00;
  localparam logic [KIND_W-1:0] KIND_SET    = 2'b01;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'b10;

  // count values with a meaning of their own
  localparam logic [CNT_W-1:0] COUNT_FREE = 2'b00;
  localparam logic [CNT_W-1:0] COUNT_ONE  = 2'b01;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_t;

  // request to the counter/hint update logic
  typedef struct packed {
    logic [POS_W-1:0] idx;
    logic             prev_free;
    logic             now_used;
    logic             alloc;
  } upd_req_t;

  // answer of the row scan unit
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } scan_res_t;

endpackage

// ===== rtl/core/rcmap_chan_if.sv =====
// rcmap_chan_if: valid/ready channel interfaces for requests and responses
// depends on rcmap_pkg for field widths

interface rcmap_req_if;
  logic                           valid;
  logic                           ready;
  logic [rcmap_pkg::KIND_W-1:0]   kind;
  logic [rcmap_pkg::IDX_W-1:0]    entry_index;
  logic [rcmap_pkg::CNT_W-1:0]    new_count;
  logic [rcmap_pkg::POS_W-1:0]    search_begin;
  logic [rcmap_pkg::POS_W-1:0]    search_end;

  modport source (output valid, kind, entry_index, new_count, search_begin, search_end,
                  input ready);
  modport sink   (input valid, kind, entry_index, new_count, search_begin, search_end,
                  output ready);
endinterface

interface rcmap_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [rcmap_pkg::CNT_W-1:0]    read_count;
  logic                           found;
  logic [rcmap_pkg::IDX_W-1:0]    found_index;
  logic [rcmap_pkg::POS_W-1:0]    free_entries;
  logic [rcmap_pkg::POS_W-1:0]    search_hint;

  modport source (output valid, read_count, found, found_index, free_entries, search_hint,
                  input ready);
  modport sink   (input valid, read_count, found, found_index, free_entries, search_hint,
                  output ready);
endinterface

// ===== rtl/core/rcmap_row_scan.sv =====
// rcmap_row_scan: finds the lowest free count of one memory row inside [lo, hi)
// depends on rcmap_pkg; shared by every step of a find

module rcmap_row_scan (
  input  logic [rcmap_pkg::ROW_BITS-1:0] row_data,
  input  logic [rcmap_pkg::SLOT_W-1:0]   lo,
  input  logic [rcmap_pkg::SLOT_W:0]     hi,
  output rcmap_pkg::scan_res_t           res
);

  logic [rcmap_pkg::ROW_ENTRIES-1:0] free_mask;

  // free entries inside the window
  always_comb begin
    for (int j = 0; j < rcmap_pkg::ROW_ENTRIES; j++) begin
      free_mask[j] = (row_data[j*rcmap_pkg::CNT_W +: rcmap_pkg::CNT_W] == rcmap_pkg::COUNT_FREE)
                     && ((rcmap_pkg::SLOT_W+1)'(j) >= {1'b0, lo})
                     && ((rcmap_pkg::SLOT_W+1)'(j) < hi);
    end
  end

  // lowest set bit wins
  always_comb begin
    res = '0;
    for (int j = rcmap_pkg::ROW_ENTRIES - 1; j >= 0; j--) begin
      if (free_mask[j]) begin
        res.hit  = 1'b1;
        res.slot = rcmap_pkg::SLOT_W'(j);
      end
    end
  end

endmodule

// ===== rtl/core/rcmap_count_update.sv =====
// rcmap_count_update: next free counter and search hint after a count change
// depends on rcmap_pkg for the request struct and limits

module rcmap_count_update (
  input  logic [rcmap_pkg::POS_W-1:0] free_cnt,
  input  logic [rcmap_pkg::POS_W-1:0] hint,
  input  rcmap_pkg::upd_req_t         req,
  output logic [rcmap_pkg::POS_W-1:0] free_next,
  output logic [rcmap_pkg::POS_W-1:0] hint_next
);

  always_comb begin
    free_next = free_cnt;
    hint_next = hint;
    // free to used
    if (req.prev_free && req.now_used) begin
      if (free_cnt != '0) free_next = free_cnt - 1'b1;
      if (req.idx == hint && hint != rcmap_pkg::POS_MAX) hint_next = hint + 1'b1;
    end
    // used to free
    if (!req.prev_free && !req.now_used) begin
      if (free_cnt != rcmap_pkg::POS_MAX) free_next = free_cnt + 1'b1;
      if (req.idx < hint) hint_next = req.idx;
    end
    // allocation puts the hint just past the entry
    if (req.alloc) begin
      hint_next = (req.idx == rcmap_pkg::POS_MAX) ? rcmap_pkg::POS_MAX : req.idx + 1'b1;
    end
  end

endmodule

// ===== rtl/core/two_bit_refcount_allocation_map_unit.sv =====
// two_bit_refcount_allocation_map_unit: top level, sequencer and count memory
// depends on rcmap_pkg, rcmap_chan_if, rcmap_row_scan, rcmap_count_update
//
// Keeps a 2-bit reference count for each of ENTRIES entries in a memory of
// 32 counts per row, plus a free counter and a search hint.
// req carries one transaction per operation (lookup, set, find); rsp returns
// exactly one result transaction for each. cfg_wr_en/cfg_wr_data reload the
// free counter with the clamped entry count.
// Sequence, from the accepting edge: a lookup or set passes through read,
// modify/write and result load, and req.ready returns once the result is
// loaded, so a new lookup or set is not accepted before the last one is done.
// A find reads and checks one memory row at a time, through the single row
// scan unit and the one memory read port, until it allocates or runs past its
// window, then loads its result. An unused kind, or an index beyond the map,
// goes straight to result load. One operation is in progress at a time;
// req.ready is high only while the sequencer is idle.
// Reset: a clearing pass writes zero to all ceil(ENTRIES/32) rows, one row a
// cycle, with req.ready low; configuration writes are taken during it.
// The result sits in an output register: a stalled receiver holds it there
// while the next operation is accepted and worked on; that operation then
// waits for the register to free up before its result is loaded.

module two_bit_refcount_allocation_map_unit #(
  parameter int ENTRIES = rcmap_pkg::ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [rcmap_pkg::POS_W-1:0] cfg_wr_data,
  rcmap_req_if.sink                   req,
  rcmap_rsp_if.source                 rsp
);

  localparam int ROWS   = (ENTRIES + rcmap_pkg::ROW_ENTRIES - 1) / rcmap_pkg::ROW_ENTRIES;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);
  // scan and index limit, never above the reach of a 13-bit position
  localparam logic [rcmap_pkg::POS_W:0] ENT_LIM =
    (ENTRIES > 8192) ? 14'd8192 : 14'(ENTRIES);
  localparam logic [rcmap_pkg::POS_W-1:0] FREE_RST =
    (ENTRIES > rcmap_pkg::RESET_ENTRIES) ? 13'(rcmap_pkg::RESET_ENTRIES) : 13'(ENTRIES);

  localparam int SW = rcmap_pkg::SLOT_W;
  localparam int PW = rcmap_pkg::POS_W;
  localparam int CW = rcmap_pkg::CNT_W;

  rcmap_pkg::state_t state, state_next;

  // control registers
  logic [ROW_AW-1:0] clr_addr;
  logic [PW-1:0]     free_cnt;
  logic [PW-1:0]     hint;
  logic              out_valid;

  // operation registers
  logic [rcmap_pkg::KIND_W-1:0] kind_r;
  logic [PW-1:0]                idx_r;
  logic [CW-1:0]                n_r;
  logic [PW:0]                  pos;
  logic [PW:0]                  stop_r;
  logic [CW-1:0]                rd_r;
  logic                         fnd_r;
  logic [PW-1:0]                fidx_r;

  // output registers
  logic [CW-1:0]                out_read_count;
  logic                         out_found;
  logic [rcmap_pkg::IDX_W-1:0]  out_found_index;
  logic [PW-1:0]                out_free_entries;
  logic [PW-1:0]                out_search_hint;

  // memory
  logic [rcmap_pkg::ROW_BITS-1:0] mem [ROWS];
  logic [rcmap_pkg::ROW_BITS-1:0] rd_data;
  logic                           mem_re, mem_we;
  logic [ROW_AW-1:0]              mem_raddr, mem_waddr;
  logic [rcmap_pkg::ROW_BITS-1:0] mem_wdata;

  // datapath signals
  logic [PW-1:0]                  start;
  logic [PW:0]                    stop_in;
  logic                           idx_ok;
  logic [PW-1:0]                  cfg_clamped;
  logic [ROW_AW-1:0]              idx_row, pos_row;
  logic [CW-1:0]                  old_count;
  logic [SW-1:0]                  scan_lo;
  logic [SW:0]                    scan_hi;
  rcmap_pkg::scan_res_t           scan_res;
  logic [PW-1:0]                  alloc_idx;
  logic [SW-1:0]                  patch_slot;
  logic [CW-1:0]                  patch_val;
  logic [rcmap_pkg::ROW_BITS-1:0] row_patched;
  logic                           upd_en;
  rcmap_pkg::upd_req_t            upd_req;
  logic [PW-1:0]                  upd_free, upd_hint;
  logic                           out_load;
  logic                           alloc_commit;

  // request decode
  assign start   = (req.search_begin > hint) ? req.search_begin : hint;
  assign stop_in = ({1'b0, req.search_end} < ENT_LIM) ? {1'b0, req.search_end} : ENT_LIM;
  assign idx_ok  = {2'b00, req.entry_index} < ENT_LIM;
  assign cfg_clamped = ({1'b0, cfg_wr_data} > ENT_LIM) ? ENT_LIM[PW-1:0] : cfg_wr_data;

  // row addressing
  assign idx_row   = ROW_AW'(idx_r >> SW);
  assign pos_row   = ROW_AW'(pos >> SW);
  assign old_count = rd_data[idx_r[SW-1:0]*CW +: CW];
  assign scan_lo   = pos[SW-1:0];
  assign scan_hi   = ((stop_r >> SW) == (pos >> SW)) ? {1'b0, stop_r[SW-1:0]}
                                                     : (SW+1)'(rcmap_pkg::ROW_ENTRIES);
  assign alloc_idx = {pos[PW-1:SW], scan_res.slot};

  rcmap_row_scan u_scan (
    .row_data (rd_data),
    .lo       (scan_lo),
    .hi       (scan_hi),
    .res      (scan_res)
  );

  rcmap_count_update u_update (
    .free_cnt  (free_cnt),
    .hint      (hint),
    .req       (upd_req),
    .free_next (upd_free),
    .hint_next (upd_hint)
  );

  assign out_load     = (state == rcmap_pkg::ST_DONE) && (!out_valid || rsp.ready);
  assign alloc_commit = (state == rcmap_pkg::ST_SCAN_CHK) && scan_res.hit;

  // row with one count replaced
  always_comb begin
    patch_slot = (state == rcmap_pkg::ST_SCAN_CHK) ? scan_res.slot : idx_r[SW-1:0];
    patch_val  = (state == rcmap_pkg::ST_SCAN_CHK) ? rcmap_pkg::COUNT_ONE : n_r;
    for (int j = 0; j < rcmap_pkg::ROW_ENTRIES; j++) begin
      row_patched[j*CW +: CW] = (SW'(j) == patch_slot) ? patch_val : rd_data[j*CW +: CW];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rcmap_pkg::ST_CLEAR: begin
        if (clr_addr == ROW_LAST) state_next = rcmap_pkg::ST_IDLE;
      end
      rcmap_pkg::ST_IDLE: begin
        if (req.valid) begin
          unique case (req.kind)
            rcmap_pkg::KIND_LOOKUP,
            rcmap_pkg::KIND_SET: state_next = idx_ok ? rcmap_pkg::ST_READ : rcmap_pkg::ST_DONE;
            rcmap_pkg::KIND_FIND: state_next = rcmap_pkg::ST_SCAN_RD;
            default: state_next = rcmap_pkg::ST_DONE;
          endcase
        end
      end
      rcmap_pkg::ST_READ:   state_next = rcmap_pkg::ST_MODIFY;
      rcmap_pkg::ST_MODIFY: state_next = rcmap_pkg::ST_DONE;
      rcmap_pkg::ST_SCAN_RD: begin
        state_next = (pos < stop_r) ? rcmap_pkg::ST_SCAN_CHK : rcmap_pkg::ST_DONE;
      end
      rcmap_pkg::ST_SCAN_CHK: begin
        state_next = scan_res.hit ? rcmap_pkg::ST_DONE : rcmap_pkg::ST_SCAN_RD;
      end
      rcmap_pkg::ST_DONE: begin
        if (out_load) state_next = rcmap_pkg::ST_IDLE;
      end
      default: state_next = rcmap_pkg::ST_IDLE;
    endcase
  end

  // state outputs: memory port and counter update
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_row;
    mem_we    = 1'b0;
    mem_waddr = idx_row;
    mem_wdata = row_patched;
    upd_en    = 1'b0;
    upd_req   = '0;
    unique case (state)
      rcmap_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      rcmap_pkg::ST_READ: begin
        mem_re = 1'b1;
      end
      rcmap_pkg::ST_MODIFY: begin
        if (kind_r == rcmap_pkg::KIND_SET) begin
          mem_we            = 1'b1;
          upd_en            = 1'b1;
          upd_req.idx       = idx_r;
          upd_req.prev_free = (old_count == rcmap_pkg::COUNT_FREE);
          upd_req.now_used  = (n_r != rcmap_pkg::COUNT_FREE);
        end
      end
      rcmap_pkg::ST_SCAN_RD: begin
        mem_re    = pos < stop_r;
        mem_raddr = pos_row;
      end
      rcmap_pkg::ST_SCAN_CHK: begin
        mem_waddr = pos_row;
        if (scan_res.hit) begin
          mem_we            = 1'b1;
          upd_en            = 1'b1;
          upd_req.idx       = alloc_idx;
          upd_req.prev_free = 1'b1;
          upd_req.now_used  = 1'b1;
          upd_req.alloc     = 1'b1;
        end
      end
      rcmap_pkg::ST_IDLE, rcmap_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // count memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcmap_pkg::ST_CLEAR;
      clr_addr  <= '0;
      free_cnt  <= FREE_RST;
      hint      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rcmap_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_wr_en) free_cnt <= cfg_clamped;
      else if (upd_en) free_cnt <= upd_free;
      if (upd_en) hint <= upd_hint;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // operation and result payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      kind_r <= req.kind;
      idx_r  <= {1'b0, req.entry_index};
      n_r    <= req.new_count;
      pos    <= {1'b0, start};
      stop_r <= stop_in;
      rd_r   <= '0;
      fnd_r  <= 1'b0;
      fidx_r <= '0;
    end
    if (state == rcmap_pkg::ST_MODIFY && kind_r == rcmap_pkg::KIND_LOOKUP) rd_r <= old_count;
    if (state == rcmap_pkg::ST_SCAN_CHK) begin
      if (scan_res.hit) begin
        fnd_r  <= 1'b1;
        fidx_r <= alloc_idx;
      end else begin
        pos <= {pos[PW:SW] + 1'b1, SW'(0)};
      end
    end
    if (out_load) begin
      out_read_count   <= rd_r;
      out_found        <= fnd_r;
      out_found_index  <= fidx_r[rcmap_pkg::IDX_W-1:0];
      out_free_entries <= free_cnt;
      out_search_hint  <= hint;
    end
  end

  // ports
  assign req.ready        = (state == rcmap_pkg::ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.read_count   = out_read_count;
  assign rsp.found        = out_found;
  assign rsp.found_index  = out_found_index;
  assign rsp.free_entries = out_free_entries;
  assign rsp.search_hint  = out_search_hint;

  // an allocation takes one free entry off the counter
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    (alloc_commit && !cfg_wr_en && free_cnt != '0) |=> free_cnt == $past(free_cnt) - 1'b1)
    else $error("free counter not decremented on allocation");

  // an allocation leaves the hint just past the allocated entry
  a_alloc_hint: assert property (@(posedge clk) disable iff (rst)
    alloc_commit |=> hint == (($past(alloc_idx) == rcmap_pkg::POS_MAX) ? rcmap_pkg::POS_MAX
                                                                        : $past(alloc_idx) + 1'b1))
    else $error("hint not moved past allocated entry");

  // a row without a free entry moves the scan forward
  a_scan_advance: assert property (@(posedge clk) disable iff (rst)
    (state == rcmap_pkg::ST_SCAN_CHK && !scan_res.hit) |=> pos > $past(pos))
    else $error("scan position did not advance");

  // results are only loaded from the done state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == rcmap_pkg::ST_DONE)
    else $error("result loaded outside done state");

endmodule
